// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file sit_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is low.
`define SIT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define SIT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sit_pkg.sv =====
// Shared types, constants and the final decision function of the
// segment intersection test. No dependencies.
package sit_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Sign of one orientation cross product; both low means zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } orient_sign_t;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
  } adv_t;

  // Pick the case from the four orientation signs and the four between bits
  // (order of btw: [0] r on pq, [1] s on pq, [2] p on rs, [3] q on rs).
  function automatic logic seg_hit(input orient_sign_t o_pqr, input orient_sign_t o_pqs,
                                   input orient_sign_t o_rsp, input orient_sign_t o_rsq,
                                   input logic [3:0] btw);
    logic z_pqr, z_pqs, z_rsp, z_rsq;
    logic zero1, zero2;
    logic hit;
    z_pqr = !o_pqr.pos && !o_pqr.neg;
    z_pqs = !o_pqs.pos && !o_pqs.neg;
    z_rsp = !o_rsp.pos && !o_rsp.neg;
    z_rsq = !o_rsq.pos && !o_rsq.neg;
    zero1 = z_pqr || z_pqs;
    zero2 = z_rsp || z_rsq;
    if (z_pqr && z_pqs && z_rsp && z_rsq) begin
      hit = |btw;
    end else if (zero1 && zero2) begin
      hit = 1'b1;
    end else if (zero1 || zero2) begin
      hit = (z_pqr && btw[0]) || (z_pqs && btw[1]) ||
            (z_rsp && btw[2]) || (z_rsq && btw[3]);
    end else begin
      hit = ((o_pqr.pos && o_pqs.neg) || (o_pqr.neg && o_pqs.pos)) &&
            ((o_rsp.pos && o_rsq.neg) || (o_rsp.neg && o_rsq.pos));
    end
    return hit;
  endfunction

endpackage

// ===== hdl/sit_if.sv =====
// Valid/ready channel interfaces for segment pairs in and intersect bits out.
// Depends on sit_pkg for the default coordinate width.
interface sit_in_if
  import sit_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p_x;
  logic signed [COORD_WIDTH-1:0] p_y;
  logic signed [COORD_WIDTH-1:0] q_x;
  logic signed [COORD_WIDTH-1:0] q_y;
  logic signed [COORD_WIDTH-1:0] r_x;
  logic signed [COORD_WIDTH-1:0] r_y;
  logic signed [COORD_WIDTH-1:0] s_x;
  logic signed [COORD_WIDTH-1:0] s_y;

  modport source (output valid, p_x, p_y, q_x, q_y, r_x, r_y, s_x, s_y, input ready);
  modport sink   (input valid, p_x, p_y, q_x, q_y, r_x, r_y, s_x, s_y, output ready);
endinterface

interface sit_out_if;
  logic valid;
  logic ready;
  logic intersect_res;

  modport source (output valid, intersect_res, input ready);
  modport sink   (input valid, intersect_res, output ready);
endinterface

// ===== hdl/sit_orient.sv =====
// Three-stage orientation unit: differences, products, signed compare.
// Gives the sign of (b-a) x (c-a). Depends on sit_pkg.
module sit_orient
  import sit_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  adv_t                          adv,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  output orient_sign_t                  sgn
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] ux_nxt, uy_nxt, vx_nxt, vy_nxt;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic signed [PW-1:0] lp_nxt, rp_nxt;
  logic signed [PW-1:0] lp_r, rp_r;
  orient_sign_t         sgn_nxt, sgn_r;

  assign ux_nxt = DW'(b_x) - DW'(a_x);
  assign uy_nxt = DW'(b_y) - DW'(a_y);
  assign vx_nxt = DW'(c_x) - DW'(a_x);
  assign vy_nxt = DW'(c_y) - DW'(a_y);

  assign lp_nxt = ux_r * vy_r;
  assign rp_nxt = uy_r * vx_r;

  assign sgn_nxt.pos = lp_r > rp_r;
  assign sgn_nxt.neg = lp_r < rp_r;

  always_ff @(posedge clk) begin
    if (adv.st1) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
    if (adv.st2) begin
      lp_r <= lp_nxt;
      rp_r <= rp_nxt;
    end
    if (adv.st3) begin
      sgn_r <= sgn_nxt;
    end
  end

  assign sgn = sgn_r;

endmodule

// ===== hdl/segment_intersection_test.sv =====
// Top level of the 2-D segment intersection test.
// Depends on sit_pkg, sit_if (sit_in_if, sit_out_if) and sit_orient.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   p_x p_y q_x q_y r_x r_y s_x s_y (signed)
//   out_ch   out  valid/ready   intersect_res
//
// One beat per cycle sustained while out_ch is ready; an input beat passes the
// difference, product and compare registers, then the decision output register.
// The product stage (eight COORD_WIDTH+1 square multipliers) sets the cycle.
// rst_n is synchronous and clears the stage valid bits only.
// A stall holds each full stage; an empty stage keeps filling.
module segment_intersection_test
  import sit_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_ch,
  sit_out_if.source out_ch
);

  // c lies in the closed range of a-b, on y when the x values match
  function automatic logic btw(input logic signed [COORD_WIDTH-1:0] ax,
                               input logic signed [COORD_WIDTH-1:0] ay,
                               input logic signed [COORD_WIDTH-1:0] bx,
                               input logic signed [COORD_WIDTH-1:0] by,
                               input logic signed [COORD_WIDTH-1:0] cx,
                               input logic signed [COORD_WIDTH-1:0] cy);
    logic res;
    if (ax == bx) begin
      res = (ay <= cy && by >= cy) || (ay >= cy && by <= cy);
    end else begin
      res = (ax <= cx && bx >= cx) || (ax >= cx && bx <= cx);
    end
    return res;
  endfunction

  adv_t         adv;
  logic         rdy1, rdy2, rdy3, rdy_out;
  logic         v1_r, v2_r, v3_r, out_valid_r;
  logic [3:0]   btw_nxt, btw1_r, btw2_r, btw3_r;
  orient_sign_t o_pqr, o_pqs, o_rsp, o_rsq;
  logic         hit_nxt, hit_r;

  // ready ripples back from the output register
  assign rdy_out = !out_valid_r || out_ch.ready;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign adv.st1 = rdy1;
  assign adv.st2 = rdy2;
  assign adv.st3 = rdy3;

  assign in_ch.ready = rdy1;

  assign btw_nxt[0] = btw(in_ch.p_x, in_ch.p_y, in_ch.q_x, in_ch.q_y, in_ch.r_x, in_ch.r_y);
  assign btw_nxt[1] = btw(in_ch.p_x, in_ch.p_y, in_ch.q_x, in_ch.q_y, in_ch.s_x, in_ch.s_y);
  assign btw_nxt[2] = btw(in_ch.r_x, in_ch.r_y, in_ch.s_x, in_ch.s_y, in_ch.p_x, in_ch.p_y);
  assign btw_nxt[3] = btw(in_ch.r_x, in_ch.r_y, in_ch.s_x, in_ch.s_y, in_ch.q_x, in_ch.q_y);

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_pqr (
    .clk(clk), .adv(adv),
    .a_x(in_ch.p_x), .a_y(in_ch.p_y), .b_x(in_ch.q_x), .b_y(in_ch.q_y),
    .c_x(in_ch.r_x), .c_y(in_ch.r_y), .sgn(o_pqr)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_pqs (
    .clk(clk), .adv(adv),
    .a_x(in_ch.p_x), .a_y(in_ch.p_y), .b_x(in_ch.q_x), .b_y(in_ch.q_y),
    .c_x(in_ch.s_x), .c_y(in_ch.s_y), .sgn(o_pqs)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_rsp (
    .clk(clk), .adv(adv),
    .a_x(in_ch.r_x), .a_y(in_ch.r_y), .b_x(in_ch.s_x), .b_y(in_ch.s_y),
    .c_x(in_ch.p_x), .c_y(in_ch.p_y), .sgn(o_rsp)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_rsq (
    .clk(clk), .adv(adv),
    .a_x(in_ch.r_x), .a_y(in_ch.r_y), .b_x(in_ch.s_x), .b_y(in_ch.s_y),
    .c_x(in_ch.q_x), .c_y(in_ch.q_y), .sgn(o_rsq)
  );

  assign hit_nxt = seg_hit(o_pqr, o_pqs, o_rsp, o_rsq, btw3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // between bits ride alongside the orientation stages
  always_ff @(posedge clk) begin
    if (rdy1) btw1_r <= btw_nxt;
    if (rdy2) btw2_r <= btw1_r;
    if (rdy3) btw3_r <= btw2_r;
    if (rdy_out) hit_r <= hit_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.intersect_res = hit_r;

endmodule

// ===== hdl/sit_checker.sv =====
// Port-level checks of the segment intersection test, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_res
);

  // a stalled result beat stays and holds its bit
  `SIT_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_res)), "stalled result beat dropped or changed")

  // reset empties the pipeline
  `SIT_ASSERT_ALWAYS(a_rst_empty, clk, (!rst_n |=> !out_valid), "result valid right after reset")

  // an open output path never backs up the input
  `SIT_ASSERT(a_flow, clk, rst_n, (out_ready |-> in_ready), "input stalled while output is ready")

  // with the output held open, an accepted input beat comes out as a result beat
  `SIT_ASSERT(a_latency, clk, rst_n, (($past(in_valid && in_ready, 4) && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) |-> out_valid), "result beat missing after four cycles")

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_res(out_ch.intersect_res)
);

// ===== bench/segment_intersection_test_tb.sv =====
// Self-checking bench for segment_intersection_test: a stimulus table, then random
// segment pairs, each intersect bit checked against the row's bit or a built-in predictor.
// Depends on sit_pkg and sit_if (sit_in_if, sit_out_if) from the RTL.
`timescale 1ns / 1ps

module segment_intersection_test_tb;
  import sit_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int NUM_RANDOM = 1326;
  localparam int PAUSE_AT = 500;
  localparam int QUIET_FROM = NUM_RANDOM - 150;
  localparam int LONG_HOLD_AFTER = 400;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT = 2000;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t qx;
    coord_t qy;
    coord_t rx;
    coord_t ry;
    coord_t sx;
    coord_t sy;
  } seg_pair_t;

  // typed: the hit bit is given in the row; otherwise the predictor decides
  typedef struct packed {
    bit        typed;
    bit        hit;
    seg_pair_t pair;
  } stim_row_t;

  typedef struct {
    seg_pair_t pair;
    bit        hit;
  } pending_hit_t;

  localparam bit TYPED = 1'b1;
  localparam bit PRED  = 1'b0;
  localparam int NUM_ROWS = 24;

  stim_row_t stim_rows [NUM_ROWS] = '{
    '{TYPED, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{TYPED, 1'b1, '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}},
    '{TYPED, 1'b0, '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX}},
    '{TYPED, 1'b1, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
    '{TYPED, 1'b1, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
    '{TYPED, 1'b0, '{0, 0, 1, 1, 2, 2, 3, 3}},
    '{PRED,  1'b0, '{0, 0, 4, 4, 2, 2, 9, 9}},
    '{PRED,  1'b0, '{5, 0, 5, 10, 5, 5, 5, 20}},
    '{PRED,  1'b0, '{5, 0, 5, 10, 5, 11, 5, 20}},
    '{TYPED, 1'b1, '{0, 0, 10, 0, 0, 0, 0, 10}},
    '{PRED,  1'b0, '{0, 0, 10, 0, 5, 0, 5, 5}},
    '{PRED,  1'b0, '{0, 0, 10, 0, 15, 0, 15, 5}},
    '{PRED,  1'b0, '{5, 5, 9, 9, 5, 0, 5, 10}},
    '{PRED,  1'b0, '{9, 9, 5, 12, 5, 0, 5, 10}},
    '{TYPED, 1'b1, '{0, 0, 10, 10, 0, 10, 10, 0}},
    '{PRED,  1'b0, '{0, 0, 10, 0, 3, 1, 5, 4}},
    '{PRED,  1'b0, '{0, 0, 10, 0, 20, -5, 20, 5}},
    '{PRED,  1'b0, '{3, 3, 3, 3, 0, 0, 1, 5}},
    '{PRED,  1'b0, '{2, 2, 2, 2, 0, 0, 4, 4}},
    '{PRED,  1'b0, '{3, 3, 3, 3, 4, 4, 4, 4}},
    '{TYPED, 1'b1, '{7, -7, 7, -7, 7, -7, 7, -7}},
    '{TYPED, 1'b1, '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN}},
    '{PRED,  1'b0, '{CMIN, 0, CMAX, 1, 0, CMIN, 1, CMAX}},
    '{PRED,  1'b0, '{0, 0, 10, 0, 0, 1, 10, 1}}
  };

  logic clk;
  logic rst_n;

  sit_in_if #(.COORD_WIDTH(CW)) in_ch ();
  sit_out_if out_ch ();

  segment_intersection_test #(.COORD_WIDTH(CW)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pending_hit_t pending_hits [$];
  bit  beat_typed;
  bit  beat_hit;
  bit  quiet;
  int  fail_count;
  int  in_beats;
  int  out_beats;
  int  hit_beats;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sign of (b-a) x (c-a), exact in 64 bits.
  function automatic int cross_sign(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    longint lhs, rhs;
    lhs = (bx - ax) * (cy - ay);
    rhs = (by - ay) * (cx - ax);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  // c inside the closed span of a-b; y decides when the segment is vertical.
  function automatic bit in_span(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    if (ax == bx)
      return (ay <= cy && by >= cy) || (ay >= cy && by <= cy);
    return (ax <= cx && bx >= cx) || (ax >= cx && bx <= cx);
  endfunction

  function automatic bit segments_touch(seg_pair_t g);
    longint px, py, qx, qy, rx, ry, sx, sy;
    int o_pqr, o_pqs, o_rsp, o_rsq;
    bit z1, z2, hit;
    px = g.px; py = g.py; qx = g.qx; qy = g.qy;
    rx = g.rx; ry = g.ry; sx = g.sx; sy = g.sy;
    o_pqr = cross_sign(px, py, qx, qy, rx, ry);
    o_pqs = cross_sign(px, py, qx, qy, sx, sy);
    o_rsp = cross_sign(rx, ry, sx, sy, px, py);
    o_rsq = cross_sign(rx, ry, sx, sy, qx, qy);
    z1 = (o_pqr == 0) || (o_pqs == 0);
    z2 = (o_rsp == 0) || (o_rsq == 0);
    if (o_pqr == 0 && o_pqs == 0 && o_rsp == 0 && o_rsq == 0) begin
      hit = in_span(px, py, qx, qy, rx, ry) || in_span(px, py, qx, qy, sx, sy) ||
            in_span(rx, ry, sx, sy, px, py) || in_span(rx, ry, sx, sy, qx, qy);
    end else if (z1 && z2) begin
      hit = 1'b1;
    end else if (z1 || z2) begin
      hit = (o_pqr == 0 && in_span(px, py, qx, qy, rx, ry)) ||
            (o_pqs == 0 && in_span(px, py, qx, qy, sx, sy)) ||
            (o_rsp == 0 && in_span(rx, ry, sx, sy, px, py)) ||
            (o_rsq == 0 && in_span(rx, ry, sx, sy, qx, qy));
    end else begin
      hit = (o_pqr * o_pqs < 0) && (o_rsp * o_rsq < 0);
    end
    return hit;
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 5))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return '1;
      4: return coord_t'(1);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic int small_int(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mix of plain random pairs and shapes that hit the collinear and touching cases.
  function automatic seg_pair_t random_pair();
    seg_pair_t g, t;
    int pick, bx, by, dx, dy, k;
    pick = $urandom_range(0, 99);
    bx = small_int(10000);
    by = small_int(10000);
    dx = ($urandom_range(0, 3) == 0) ? 0 : small_int(50);
    dy = ($urandom_range(0, 3) == 0) ? 0 : small_int(50);
    g = seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    if (pick < 20) begin
      return g;
    end else if (pick < 45) begin
      g = '{coord_t'(small_int(4)), coord_t'(small_int(4)), coord_t'(small_int(4)),
            coord_t'(small_int(4)), coord_t'(small_int(4)), coord_t'(small_int(4)),
            coord_t'(small_int(4)), coord_t'(small_int(4))};
    end else if (pick < 65) begin
      k = small_int(8); g.px = coord_t'(bx + k * dx); g.py = coord_t'(by + k * dy);
      k = small_int(8); g.qx = coord_t'(bx + k * dx); g.qy = coord_t'(by + k * dy);
      k = small_int(8); g.rx = coord_t'(bx + k * dx); g.ry = coord_t'(by + k * dy);
      k = small_int(8); g.sx = coord_t'(bx + k * dx); g.sy = coord_t'(by + k * dy);
    end else if (pick < 85) begin
      k = int'($urandom_range(0, 8)) - 2;
      g.px = coord_t'(bx);          g.py = coord_t'(by);
      g.qx = coord_t'(bx + 4 * dx); g.qy = coord_t'(by + 4 * dy);
      g.rx = coord_t'(bx + k * dx); g.ry = coord_t'(by + k * dy);
      g.sx = coord_t'(bx + k * dx + small_int(60));
      g.sy = coord_t'(by + k * dy + small_int(60));
    end else begin
      g = '{edge_coord(), edge_coord(), edge_coord(), edge_coord(),
            edge_coord(), edge_coord(), edge_coord(), edge_coord()};
    end
    // scramble roles so the touching point lands on every endpoint
    if ($urandom_range(0, 1)) begin
      t = g;
      g = '{t.rx, t.ry, t.sx, t.sy, t.px, t.py, t.qx, t.qy};
    end
    if ($urandom_range(0, 1)) begin
      t = g;
      g = '{t.qx, t.qy, t.px, t.py, t.rx, t.ry, t.sx, t.sy};
    end
    if ($urandom_range(0, 1)) begin
      t = g;
      g = '{t.px, t.py, t.qx, t.qy, t.sx, t.sy, t.rx, t.ry};
    end
    return g;
  endfunction

  task automatic send_pair(input seg_pair_t g, input bit typed, input bit hit);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.p_x <= g.px; in_ch.p_y <= g.py;
    in_ch.q_x <= g.qx; in_ch.q_y <= g.qy;
    in_ch.r_x <= g.rx; in_ch.r_y <= g.ry;
    in_ch.s_x <= g.sx; in_ch.s_y <= g.sy;
    beat_typed <= typed;
    beat_hit <= hit;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic maybe_idle();
    int n;
    if (quiet || $urandom_range(0, 4) != 0) return;
    n = $urandom_range(1, 6);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Scoreboard: record accepted input beats, then check result beats in order.
  always @(posedge clk) begin
    pending_hit_t ph;
    seg_pair_t g;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        g = '{in_ch.p_x, in_ch.p_y, in_ch.q_x, in_ch.q_y,
              in_ch.r_x, in_ch.r_y, in_ch.s_x, in_ch.s_y};
        ph.pair = g;
        ph.hit = beat_typed ? beat_hit : segments_touch(g);
        pending_hits.push_back(ph);
        in_beats++;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (out_ch.intersect_res === 1'b1) hit_beats++;
        if (pending_hits.size() == 0) begin
          $display("%0t: result beat %b with nothing outstanding", $time,
                   out_ch.intersect_res);
          fail_count++;
        end else begin
          ph = pending_hits.pop_front();
          if (out_ch.intersect_res !== ph.hit) begin
            $display("%0t: intersect_res mismatch, expected %0b, actual %b", $time,
                     ph.hit, out_ch.intersect_res);
            $display("  p=(%0d,%0d) q=(%0d,%0d) r=(%0d,%0d) s=(%0d,%0d)",
                     ph.pair.px, ph.pair.py, ph.pair.qx, ph.pair.qy,
                     ph.pair.rx, ph.pair.ry, ph.pair.sx, ph.pair.sy);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side backpressure: short random bursts, plus one long hold to fill the pipe.
  initial begin
    int hold_left;
    bit long_done;
    bit rdy;
    hold_left = 0;
    long_done = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!long_done && out_beats >= LONG_HOLD_AFTER) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 5);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int drain;
    in_ch.valid = 1'b0;
    in_ch.p_x = '0; in_ch.p_y = '0; in_ch.q_x = '0; in_ch.q_y = '0;
    in_ch.r_x = '0; in_ch.r_y = '0; in_ch.s_x = '0; in_ch.s_y = '0;
    beat_typed = 1'b0;
    beat_hit = 1'b0;
    quiet = 1'b0;
    fail_count = 0;
    in_beats = 0;
    out_beats = 0;
    hit_beats = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      send_pair(stim_rows[i].pair, stim_rows[i].typed, stim_rows[i].hit);
      maybe_idle();
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == QUIET_FROM) quiet = 1'b1;
      if (n == PAUSE_AT) begin
        // drop valid and hold until the pipe has drained
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending_hits.size() == 0);
      end
      send_pair(random_pair(), PRED, 1'b0);
      maybe_idle();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain = 0;
    while (pending_hits.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_hits.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_hits.size());
      fail_count++;
    end
    repeat (8) @(posedge clk);

    $display("Ran %0d table rows and %0d random segment pairs (%0d beats in, %0d out).",
             NUM_ROWS, NUM_RANDOM, in_beats, out_beats);
    $display("Results: %0d touching or crossing, %0d apart; %0d failures.",
             hit_beats, out_beats - hit_beats, fail_count);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
